/* rtl/dvst_pkg.sv */
// Shared types, codes and constants for the dense visible slot table.
package dvst_pkg;

   localparam int DEF_BLOCK_COUNT  = 4096;
   localparam int DEF_PAYLOAD_BITS = 32;

   localparam int BLOCK_W   = 12;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = 13;
   localparam int ACTION_W  = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE   = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MOVE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic lookup;
      logic move;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic need_move;
   } sts_type;

endpackage

/* rtl/dvst_ctrl.sv */
// Sequencer that steps each request through lookup, relocation when needed, and response.
module dvst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  dvst_pkg::sts_type sts,
   output dvst_pkg::cmd_type cmd
);
   import dvst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = sts.need_move ? ST_MOVE : ST_RESULT;
         end
         ST_MOVE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_RESULT);
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.lookup = (state_ff == ST_LOOKUP);
      cmd.move   = (state_ff == ST_MOVE);
   end

endmodule

/* rtl/dvst_store.sv */
// Back-pointer and packed-list memories with the shared count adder and compares.
module dvst_store #(
   parameter int BLOCK_COUNT  = dvst_pkg::DEF_BLOCK_COUNT,
   parameter int PAYLOAD_BITS = dvst_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dvst_pkg::cmd_type                 cmd,
   input  logic [dvst_pkg::BLOCK_W-1:0]      req_block_index,
   input  logic                              req_exposed_now,
   input  logic [dvst_pkg::PAYLOAD_W-1:0]    req_payload,
   output dvst_pkg::sts_type                 sts,
   output logic [dvst_pkg::ACTION_W-1:0]     rsp_action,
   output logic [dvst_pkg::BLOCK_W-1:0]      rsp_slot,
   output logic                              rsp_moved_valid,
   output logic [dvst_pkg::BLOCK_W-1:0]      rsp_moved_block,
   output logic [dvst_pkg::COUNT_W-1:0]      rsp_live_count,
   output logic                              rsp_list_changed
);
   import dvst_pkg::*;

   localparam int AW = $clog2(BLOCK_COUNT);
   localparam int CW = $clog2(BLOCK_COUNT + 1);

   logic [AW:0]             ptr_mem [BLOCK_COUNT];
   logic [AW-1:0]           pk_blk_mem [BLOCK_COUNT];
   logic [PAYLOAD_BITS-1:0] pk_pay_mem [BLOCK_COUNT];

   logic [AW-1:0]           clr_addr_ff;
   logic [AW-1:0]           clr_addr_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic [AW-1:0]           blk_ff;
   logic                    in_range_ff;
   logic                    exposed_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [AW:0]             ptr_rd_ff;
   logic [AW-1:0]           slot_ff;
   logic [AW-1:0]           mb_rd_ff;
   logic [PAYLOAD_BITS-1:0] pay_rd_ff;
   action_type              act_ff;
   logic [AW-1:0]           rslot_ff;
   logic                    mvalid_ff;
   logic [AW-1:0]           mblk_ff;

   logic                    ptr_valid;
   logic [AW-1:0]           ptr_slot;
   logic [CW-1:0]           slot_ext;
   logic [CW-1:0]           step;
   logic [CW-1:0]           count_adj;
   logic                    full;
   logic                    hit_add;
   logic                    hit_rm;
   logic                    rm_clear;
   logic                    need_move;
   logic                    ptr_we;
   logic [AW-1:0]           ptr_waddr;
   logic [AW:0]             ptr_wdata;
   logic                    pk_we;
   logic [AW-1:0]           pk_waddr;
   logic [AW-1:0]           pk_wblk;
   logic [PAYLOAD_BITS-1:0] pk_wpay;

   // One adder serves both the append increment and the remove decrement.
   always_comb begin
      ptr_valid = ptr_rd_ff[AW];
      ptr_slot  = ptr_rd_ff[AW-1:0];
      slot_ext  = CW'(ptr_slot);
      step      = exposed_ff ? CW'(1) : {CW{1'b1}};
      count_adj = count_ff + step;
      full      = (count_ff == CW'(BLOCK_COUNT));
      hit_add   = in_range_ff && exposed_ff && !ptr_valid && !full;
      rm_clear  = in_range_ff && !exposed_ff && ptr_valid;
      hit_rm    = rm_clear && (slot_ext < count_ff);
      need_move = hit_rm && (slot_ext != count_adj);
   end

   always_comb begin
      sts.clear_done = (clr_addr_ff == AW'(BLOCK_COUNT - 1));
      sts.need_move  = need_move;
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clear) clr_addr_in = clr_addr_ff + AW'(1);
      count_in = count_ff;
      if (cmd.lookup && (hit_add || hit_rm)) count_in = count_adj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         count_ff    <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      ptr_we    = 1'b0;
      ptr_waddr = blk_ff;
      ptr_wdata = '0;
      if (cmd.clear) begin
         ptr_we    = 1'b1;
         ptr_waddr = clr_addr_ff;
      end else if (cmd.lookup && hit_add) begin
         ptr_we    = 1'b1;
         ptr_wdata = {1'b1, count_ff[AW-1:0]};
      end else if (cmd.lookup && rm_clear) begin
         ptr_we    = 1'b1;
      end else if (cmd.move) begin
         ptr_we    = 1'b1;
         ptr_waddr = mb_rd_ff;
         ptr_wdata = {1'b1, slot_ff};
      end
   end

   always_comb begin
      pk_we    = 1'b0;
      pk_waddr = count_ff[AW-1:0];
      pk_wblk  = blk_ff;
      pk_wpay  = pay_ff;
      if (cmd.lookup && hit_add) begin
         pk_we = 1'b1;
      end else if (cmd.move) begin
         pk_we    = 1'b1;
         pk_waddr = slot_ff;
         pk_wblk  = mb_rd_ff;
         pk_wpay  = pay_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ptr_we) ptr_mem[ptr_waddr] <= ptr_wdata;
      if (cmd.load) ptr_rd_ff <= ptr_mem[AW'(req_block_index)];
   end

   always_ff @(posedge clock) begin
      if (pk_we) begin
         pk_blk_mem[pk_waddr] <= pk_wblk;
         pk_pay_mem[pk_waddr] <= pk_wpay;
      end
      if (cmd.lookup) begin
         mb_rd_ff  <= pk_blk_mem[count_adj[AW-1:0]];
         pay_rd_ff <= pk_pay_mem[count_adj[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff      <= AW'(req_block_index);
         in_range_ff <= (17'(req_block_index) < 17'(BLOCK_COUNT));
         exposed_ff  <= req_exposed_now;
         pay_ff      <= PAYLOAD_BITS'(req_payload);
      end
      if (cmd.lookup) begin
         slot_ff   <= ptr_slot;
         mvalid_ff <= need_move;
         mblk_ff   <= '0;
         if (hit_add) begin
            act_ff   <= ACT_ADD;
            rslot_ff <= count_ff[AW-1:0];
         end else if (hit_rm) begin
            act_ff   <= ACT_REMOVE;
            rslot_ff <= ptr_slot;
         end else begin
            act_ff   <= ACT_NONE;
            rslot_ff <= '0;
         end
      end
      if (cmd.move) mblk_ff <= mb_rd_ff;
   end

   always_comb begin
      rsp_action       = act_ff;
      rsp_slot         = BLOCK_W'(rslot_ff);
      rsp_moved_valid  = mvalid_ff;
      rsp_moved_block  = BLOCK_W'(mblk_ff);
      rsp_live_count   = COUNT_W'(count_ff);
      rsp_list_changed = (act_ff != ACT_NONE);
   end

endmodule

/* rtl/dense_visible_slot_table.sv */
// Top level of the dense visible slot table: packed list with swap-remove.
//
// Each request names a block, its new exposed flag and a payload word. The
// block appends the block to the packed list when it becomes exposed, or
// frees its slot when it becomes hidden, moving the last entry into the hole.
// Every request yields exactly one response carrying the action, the slot,
// any relocated block and the live count after the request.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low.
// An accepted request passes through the LOOKUP and RESULT states, with a MOVE
// state between them when the last entry must be relocated; MOVE rewrites the
// relocated block's back-pointer and packed entry from the packed block memory
// read made in LOOKUP. The next request is accepted in the cycle after the
// response is taken. After reset the back-pointer memory is swept clear, one
// entry per cycle; req_stall stays high meanwhile and the list is empty.
// While rsp_stall is high the response is held unchanged and no new request
// is accepted.
module dense_visible_slot_table #(
   parameter int BLOCK_COUNT  = dvst_pkg::DEF_BLOCK_COUNT,
   parameter int PAYLOAD_BITS = dvst_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dvst_pkg::BLOCK_W-1:0]   req_block_index,
   input  logic                           req_exposed_now,
   input  logic [dvst_pkg::PAYLOAD_W-1:0] req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dvst_pkg::ACTION_W-1:0]  rsp_action,
   output logic [dvst_pkg::BLOCK_W-1:0]   rsp_slot,
   output logic                           rsp_moved_valid,
   output logic [dvst_pkg::BLOCK_W-1:0]   rsp_moved_block,
   output logic [dvst_pkg::COUNT_W-1:0]   rsp_live_count,
   output logic                           rsp_list_changed
);
   import dvst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dvst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dvst_store #(
      .BLOCK_COUNT  (BLOCK_COUNT),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_store (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_block_index  (req_block_index),
      .req_exposed_now  (req_exposed_now),
      .req_payload      (req_payload),
      .sts              (sts),
      .rsp_action       (rsp_action),
      .rsp_slot         (rsp_slot),
      .rsp_moved_valid  (rsp_moved_valid),
      .rsp_moved_block  (rsp_moved_block),
      .rsp_live_count   (rsp_live_count),
      .rsp_list_changed (rsp_list_changed)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
      else $error("request accepted while the table was not busy afterward");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_live_count) <= BLOCK_COUNT))
      else $error("live count exceeds the table depth");

   a_move_on_remove: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_moved_valid) |-> (rsp_action == ACT_REMOVE))
      else $error("relocation reported without a remove");

   a_add_at_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_ADD) |->
         (rsp_slot == BLOCK_W'(rsp_live_count - COUNT_W'(1))))
      else $error("added block not placed at the tail of the list");

endmodule
